FILE: rtl/rs_enc_pkg.sv
`default_nettype none

package rs_enc_pkg;

  localparam int MAX_ECC_LEN = 31;
  localparam logic [8:0] GF_POLY = 9'h11d;

  typedef logic [7:0] gf_byte_t;

  // Control that every cell of the remainder chain sees in the same cycle.
  typedef struct packed {
    logic absorb;  // a data byte is taken this cycle
    logic load;    // that byte ends the message: move the remainder to the drain
    logic shift;   // a parity byte leaves the drain this cycle
  } rs_enc_ctrl_t;

  // GF(256) product with field polynomial 0x11d.
  function automatic gf_byte_t gf_mul(input gf_byte_t x, input gf_byte_t y);
    logic [8:0] a;
    gf_byte_t acc;
    acc = '0;
    a = {1'b0, x};
    for (int k = 0; k < 8; k++) begin
      if (y[k]) begin
        acc = acc ^ a[7:0];
      end
      a = {a[7:0], 1'b0};
      if (a[8]) begin
        a = a ^ GF_POLY;
      end
    end
    return acc;
  endfunction

  // Coefficient idx of g(x) = (x - a^0)(x - a^1)...(x - a^(ecc_len-1)).
  // Only evaluated at elaboration to set each cell's constant multiplier.
  function automatic gf_byte_t rs_gen_coef(input int ecc_len, input int idx);
    gf_byte_t g [0:MAX_ECC_LEN];
    gf_byte_t root;
    for (int j = 0; j <= MAX_ECC_LEN; j++) begin
      g[j] = '0;
    end
    g[0] = 8'h01;
    root = 8'h01;
    for (int i = 0; i < ecc_len; i++) begin
      for (int j = ecc_len; j >= 1; j--) begin
        g[j] = g[j-1] ^ gf_mul(g[j], root);
      end
      g[0] = gf_mul(g[0], root);
      root = gf_mul(root, 8'h02);
    end
    return g[idx];
  endfunction

endpackage

`default_nettype wire

FILE: rtl/rs_enc_cell.sv
`default_nettype none

module rs_enc_cell
  import rs_enc_pkg::*;
#(
  parameter logic [7:0] COEF = 8'h01
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire rs_enc_ctrl_t ctrl,
  input  wire gf_byte_t     lead,
  input  wire gf_byte_t     rem_in,
  input  wire gf_byte_t     drain_in,
  output gf_byte_t          rem,
  output gf_byte_t          drain
);

  gf_byte_t rem_calc;

  assign rem_calc = rem_in ^ gf_mul(lead, COEF);

  always_ff @(posedge clk) begin
    if (rst) begin
      rem <= '0;
    end else if (ctrl.absorb) begin
      rem <= ctrl.load ? '0 : rem_calc;
    end
  end

  // The drain register captures the final remainder and then shifts toward the top cell.
  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      drain <= rem_calc;
    end else if (ctrl.shift) begin
      drain <= drain_in;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/reed_solomon_parity_encoder.sv
// Systematic Reed-Solomon parity encoder over GF(256), field polynomial 0x11d.
// Input channel (in_valid/in_ready): one message byte per transaction, with
// last_byte set on the final byte. Output channel (out_valid/out_ready): one
// parity byte per transaction, highest remainder coefficient first, with
// parity_last set on the ECC_LEN-th byte.
// The remainder lives in a chain of ECC_LEN cells, each with a constant GF
// multiplier, so a byte is absorbed every cycle that in_ready is high. When the
// last byte is taken, the new remainder is copied into a parallel drain
// register in the same cells and the remainder clears, so the next message
// can start at once. The first parity byte is valid the cycle after the
// last byte is accepted; the drain shifts out one byte per cycle while
// out_ready is high. Throughput: one byte per cycle while in_ready is high;
// a last byte is held off while a previous parity block has more than one
// byte to deliver, or one byte that out_ready does not take this cycle.
// A stalled receiver freezes the drain; non-last bytes keep flowing.
// Reset clears the remainder and empties the drain.
`default_nettype none

module reed_solomon_parity_encoder
  import rs_enc_pkg::*;
#(
  parameter int ECC_LEN = 26
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] data_byte,
  input  wire logic       last_byte,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [7:0]      parity_byte,
  output logic            parity_last
);

  localparam int CNT_W = $clog2(ECC_LEN + 1);

  logic [CNT_W-1:0] cnt;
  rs_enc_ctrl_t ctrl;
  gf_byte_t lead;
  gf_byte_t rem_q [ECC_LEN];
  gf_byte_t drain_q [ECC_LEN];
  logic in_fire;
  logic out_fire;
  logic drain_free;

  assign out_valid   = (cnt != '0);
  assign out_fire    = out_valid && out_ready;
  assign drain_free  = (cnt == '0) || ((cnt == CNT_W'(1)) && out_ready);
  assign in_ready    = !last_byte || drain_free;
  assign in_fire     = in_valid && in_ready;
  assign parity_byte = drain_q[ECC_LEN-1];
  assign parity_last = (cnt == CNT_W'(1));
  assign lead        = data_byte ^ rem_q[ECC_LEN-1];

  assign ctrl.absorb = in_fire;
  assign ctrl.load   = in_fire && last_byte;
  assign ctrl.shift  = out_fire;

  genvar j;
  generate
    for (j = 0; j < ECC_LEN; j++) begin : g_cell
      gf_byte_t rem_in;
      gf_byte_t drain_in;
      if (j == 0) begin : g_first
        assign rem_in   = '0;
        assign drain_in = '0;
      end else begin : g_rest
        assign rem_in   = rem_q[j-1];
        assign drain_in = drain_q[j-1];
      end
      rs_enc_cell #(
        .COEF(rs_gen_coef(ECC_LEN, j))
      ) u_cell (
        .clk     (clk),
        .rst     (rst),
        .ctrl    (ctrl),
        .lead    (lead),
        .rem_in  (rem_in),
        .drain_in(drain_in),
        .rem     (rem_q[j]),
        .drain   (drain_q[j])
      );
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (ctrl.load) begin
      cnt <= CNT_W'(ECC_LEN);
    end else if (out_fire) begin
      cnt <= cnt - CNT_W'(1);
    end
  end

  a_cnt_range: assert property (@(posedge clk) disable iff (rst)
    cnt <= CNT_W'(ECC_LEN))
    else $error("parity count above ECC_LEN");

  a_load_starts_drain: assert property (@(posedge clk) disable iff (rst)
    in_fire && last_byte |=> out_valid && (cnt == CNT_W'(ECC_LEN)))
    else $error("parity block did not start after last byte");

  a_rem_cleared: assert property (@(posedge clk) disable iff (rst)
    in_fire && last_byte |=> (rem_q[ECC_LEN-1] == '0) && (rem_q[0] == '0))
    else $error("remainder not cleared after message");

  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    in_fire && last_byte |-> (cnt == '0) || ((cnt == CNT_W'(1)) && out_ready))
    else $error("last byte taken while parity block still draining");

endmodule

`default_nettype wire
